// ===== hw/rtl/gbfs_pkg.sv =====
`timescale 1ns / 1ps

package gbfs_pkg;

	localparam int VW         = 5;
	localparam int EDGE_W     = 2 * VW;
	localparam int VMAP_BITS  = 32;
	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_PW    = FIFO_AW + 1;

	localparam logic MODE_ADD_EDGE = 1'b0;
	localparam logic MODE_TRAVERSE = 1'b1;

	typedef logic [VW-1:0] vertex_t;

	// controller to datapath
	typedef struct packed {
		logic add_edge;
		logic start;
		logic pop;
		logic scan;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_ok;
		logic edges_zero;
		logic rem_zero;
		logic fifo_empty;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/gbfs_ctrl.sv =====
`timescale 1ns / 1ps

module gbfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              mode,
	input  gbfs_pkg::dp_sts_t sts,
	output logic              in_stall,
	output gbfs_pkg::dp_cmd_t cmd
);
	import gbfs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_SCAN = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode == MODE_TRAVERSE) begin
						cmd.start = 1'b1;
						if (sts.start_ok) begin
							state_d = S_POP;
						end
					end else begin
						cmd.add_edge = 1'b1;
					end
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = sts.edges_zero ? S_EMIT : S_SCAN;
			end
			S_SCAN: begin
				// one edge checked per cycle, newest first
				cmd.scan = 1'b1;
				if (sts.rem_zero) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.fifo_empty ? S_IDLE : S_POP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/gbfs_datapath.sv =====
`timescale 1ns / 1ps

module gbfs_datapath #(
	parameter int NUM_VERTICES = 32,
	parameter int MAX_EDGES    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbfs_pkg::dp_cmd_t cmd,
	output gbfs_pkg::dp_sts_t sts,
	input  gbfs_pkg::vertex_t vertex_a,
	input  gbfs_pkg::vertex_t vertex_b,
	input  logic              out_stall,
	output logic              out_valid,
	output gbfs_pkg::vertex_t visited_vertex,
	output logic              last_vertex,
	output logic              edge_overflow
);
	import gbfs_pkg::*;

	localparam int AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW     = $clog2(MAX_EDGES + 1);
	localparam int USABLE = (NUM_VERTICES < VMAP_BITS) ? NUM_VERTICES : VMAP_BITS;

	logic [EDGE_W-1:0]    edge_mem [MAX_EDGES];
	logic [EDGE_W-1:0]    rd_data_q;
	logic [CW-1:0]        edge_cnt_q;
	logic [AW-1:0]        rem_q;
	logic [AW-1:0]        rd_addr;
	logic                 rd_en;
	logic                 ovf_q;
	logic [VMAP_BITS-1:0] visited_q;
	vertex_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   head_q;
	logic [FIFO_PW-1:0]   tail_q;
	vertex_t              cur_q;
	logic                 out_valid_q;
	vertex_t              out_vertex_q;
	logic                 out_last_q;
	logic                 out_ovf_q;

	logic [VW:0] usable_c;
	logic        a_ok;
	logic        b_ok;
	logic        edge_full;
	logic        edge_wr;
	vertex_t     ea;
	vertex_t     eb;
	logic        hit_a;
	logic        hit;
	vertex_t     nb;
	logic        push;

	assign usable_c  = (VW + 1)'(USABLE);
	assign a_ok      = {1'b0, vertex_a} < usable_c;
	assign b_ok      = {1'b0, vertex_b} < usable_c;
	assign edge_full = edge_cnt_q == CW'(MAX_EDGES);
	assign edge_wr   = cmd.add_edge && a_ok && b_ok && !edge_full;

	assign rd_en   = (cmd.pop && edge_cnt_q != '0) || (cmd.scan && rem_q != '0);
	assign rd_addr = cmd.pop ? AW'(edge_cnt_q - CW'(1)) : rem_q - AW'(1);

	// an edge gives at most one new neighbour: both ends match only on a self loop
	assign ea    = rd_data_q[EDGE_W-1:VW];
	assign eb    = rd_data_q[VW-1:0];
	assign hit_a = ea == cur_q;
	assign hit   = hit_a || (eb == cur_q);
	assign nb    = hit_a ? eb : ea;
	assign push  = cmd.scan && hit && !visited_q[nb];

	always_ff @(posedge clk) begin
		if (edge_wr) begin
			edge_mem[edge_cnt_q[AW-1:0]] <= {vertex_a, vertex_b};
		end
		if (rd_en) begin
			rd_data_q <= edge_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.add_edge && a_ok && b_ok) begin
				if (edge_full) begin
					ovf_q <= 1'b1;
				end else begin
					edge_cnt_q <= edge_cnt_q + CW'(1);
				end
			end
			if (cmd.start) begin
				head_q <= '0;
				if (a_ok) begin
					visited_q <= VMAP_BITS'(1) << vertex_a;
					tail_q    <= FIFO_PW'(1);
				end else begin
					visited_q <= '0;
					tail_q    <= '0;
				end
			end
			if (cmd.pop) begin
				head_q <= head_q + FIFO_PW'(1);
				rem_q  <= AW'(edge_cnt_q - CW'(1));
			end
			if (cmd.scan) begin
				if (rem_q != '0) begin
					rem_q <= rem_q - AW'(1);
				end
				if (push) begin
					visited_q[nb] <= 1'b1;
					tail_q        <= tail_q + FIFO_PW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && a_ok) begin
			fifo_q[0] <= vertex_a;
		end
		if (push) begin
			fifo_q[tail_q[FIFO_AW-1:0]] <= nb;
		end
		if (cmd.pop) begin
			cur_q <= fifo_q[head_q[FIFO_AW-1:0]];
		end
		if (cmd.emit) begin
			out_vertex_q <= cur_q;
			out_last_q   <= head_q == tail_q;
			out_ovf_q    <= ovf_q;
		end
	end

	assign sts.start_ok   = a_ok;
	assign sts.edges_zero = edge_cnt_q == '0;
	assign sts.rem_zero   = rem_q == '0;
	assign sts.fifo_empty = head_q == tail_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign last_vertex    = out_last_q;
	assign edge_overflow  = out_ovf_q;

endmodule

// ===== hw/rtl/graph_bfs_engine.sv =====
`timescale 1ns / 1ps

// Breadth-first traversal over an undirected graph held as a bounded edge store.
// An add-edge item never stalls the input and the next item may follow at once; an
// edge with an end outside the usable vertex range is dropped, and one that
// finds the store full is dropped and sets the sticky edge_overflow flag.
// A traverse item first starts the walk; then, for each vertex visited, it
// dequeues the vertex, checks one edge per cycle through the single read port
// of the edge store, and hands the vertex to the output register, waiting
// while the output stalls; input stays stalled until the last vertex is in
// the output register. Vertices come out in visit order with last_vertex set
// on the final one; a start vertex out of range gives no result.

module graph_bfs_engine #(
	parameter int NUM_VERTICES = 32,
	parameter int MAX_EDGES    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  gbfs_pkg::vertex_t vertex_a,
	input  gbfs_pkg::vertex_t vertex_b,
	output logic              out_valid,
	input  logic              out_stall,
	output gbfs_pkg::vertex_t visited_vertex,
	output logic              last_vertex,
	output logic              edge_overflow
);
	import gbfs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	gbfs_datapath #(
		.NUM_VERTICES (NUM_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.visited_vertex (visited_vertex),
		.last_vertex    (last_vertex),
		.edge_overflow  (edge_overflow)
	);

endmodule

// ===== hw/rtl/gbfs_checker.sv =====
`timescale 1ns / 1ps

module gbfs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              mode,
	input logic              out_valid,
	input logic              out_stall,
	input gbfs_pkg::vertex_t visited_vertex,
	input logic              last_vertex,
	input logic              edge_overflow
);
	import gbfs_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visited_vertex)
			&& $stable(last_vertex) && $stable(edge_overflow))
		else $error("stalled result changed");

	// while a non-final vertex is pending the traversal is still running
	a_busy_mid_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_vertex |-> in_stall)
		else $error("input taken during a traversal");

	// edge loads never block the next item
	a_edge_stream: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_ADD_EDGE |=> !in_stall)
		else $error("stall after edge load");

	// overflow is sticky once reported
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && edge_overflow |=> !out_valid || edge_overflow)
		else $error("overflow flag cleared");

endmodule

bind graph_bfs_engine gbfs_checker u_gbfs_checker (.*);

// ===== test/graph_bfs_engine_test.sv =====
`timescale 1ns / 1ps

module graph_bfs_engine_test;
	import gbfs_pkg::*;

	localparam int N_VERT      = 32;
	localparam int N_EDGE      = 64;
	localparam int USABLE      = (N_VERT < 32) ? N_VERT : 32;
	localparam int ITEM_TOTAL  = 360;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 100;
	localparam int SHOW_MAX    = 10;

	typedef struct packed {
		vertex_t vtx;
		logic    fin;
		logic    ovf;
	} visit_t;

	typedef struct {
		logic    md;
		vertex_t va;
		vertex_t vb;
		bit      drain;
	} bfs_item_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	logic    mode = MODE_ADD_EDGE;
	vertex_t vertex_a = '0;
	vertex_t vertex_b = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	vertex_t visited_vertex;
	logic    last_vertex;
	logic    edge_overflow;

	bfs_item_t pending_items[$];
	visit_t    visit_expect[$];

	// shadow of the edge store
	vertex_t edge_end_a [N_EDGE];
	vertex_t edge_end_b [N_EDGE];
	int      edge_total = 0;
	logic    overflow_seen = 1'b0;

	int   items_sent = 0;
	int   mismatches = 0;
	int   quiet_cycles = 0;
	logic calm;

	assign calm = (items_sent >= 200) && (items_sent < 260);

	graph_bfs_engine #(
		.NUM_VERTICES(N_VERT),
		.MAX_EDGES   (N_EDGE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.visited_vertex(visited_vertex),
		.last_vertex   (last_vertex),
		.edge_overflow (edge_overflow)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic queue_item(input logic md, input int va, input int vb, input bit drain);
		bfs_item_t it;
		it.md    = md;
		it.va    = vertex_t'(va);
		it.vb    = vertex_t'(vb);
		it.drain = drain;
		pending_items.push_back(it);
	endtask

	// mostly near a base vertex so that separate clusters form
	function automatic int pick_vertex(input int base);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 31);
		return (base + $urandom_range(0, 6)) % 32;
	endfunction

	task automatic predict_visits(input logic md, input vertex_t va, input vertex_t vb);
		logic [31:0] seen;
		vertex_t     order [32];
		int          head;
		int          tail;
		int          e;
		vertex_t     cur;
		visit_t      r;
		if (md == MODE_ADD_EDGE) begin
			if (int'(va) < USABLE && int'(vb) < USABLE) begin
				if (edge_total >= N_EDGE) begin
					overflow_seen = 1'b1;
				end else begin
					edge_end_a[edge_total] = va;
					edge_end_b[edge_total] = vb;
					edge_total++;
				end
			end
		end else if (int'(va) < USABLE) begin
			seen     = '0;
			seen[va] = 1'b1;
			order[0] = va;
			head     = 0;
			tail     = 1;
			while (head < tail) begin
				cur = order[head];
				head++;
				// newest edge first, first end checked first
				for (e = edge_total - 1; e >= 0; e--) begin
					if (edge_end_a[e] == cur && !seen[edge_end_b[e]]) begin
						seen[edge_end_b[e]] = 1'b1;
						order[tail] = edge_end_b[e];
						tail++;
					end
					if (edge_end_b[e] == cur && !seen[edge_end_a[e]]) begin
						seen[edge_end_a[e]] = 1'b1;
						order[tail] = edge_end_a[e];
						tail++;
					end
				end
				r.vtx = cur;
				r.fin = (head == tail);
				r.ovf = overflow_seen;
				visit_expect.push_back(r);
			end
		end
	endtask

	task automatic check_visit();
		visit_t want;
		if (visit_expect.size() == 0) begin
			if (mismatches < SHOW_MAX)
				$display("unexpected transfer: vertex %0d last %0b overflow %0b",
					visited_vertex, last_vertex, edge_overflow);
			mismatches++;
		end else begin
			want = visit_expect.pop_front();
			if (visited_vertex !== want.vtx || last_vertex !== want.fin ||
			    edge_overflow !== want.ovf) begin
				if (mismatches < SHOW_MAX)
					$display("mismatch: expected vertex %0d last %0b overflow %0b, got %0d %0b %0b",
						want.vtx, want.fin, want.ovf,
						visited_vertex, last_vertex, edge_overflow);
				mismatches++;
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode     <= MODE_ADD_EDGE;
			vertex_a <= '0;
			vertex_b <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_visits(mode, vertex_a, vertex_b);
				items_sent <= items_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 &&
				    !(pending_items[0].drain && visit_expect.size() != 0) &&
				    (calm || $urandom_range(0, 99) >= 31)) begin
					in_valid <= 1'b1;
					mode     <= pending_items[0].md;
					vertex_a <= pending_items[0].va;
					vertex_b <= pending_items[0].vb;
					pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_visit();
			out_stall <= !calm && ($urandom_range(0, 99) < 31);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("graph_bfs_engine_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int edges_made;
		int base;
		int n;
		bit drain;
		// empty store, extreme start vertices
		queue_item(MODE_TRAVERSE, 0, 7, 0);
		queue_item(MODE_TRAVERSE, 31, 31, 0);
		// duplicate pair in both orders, self loop
		queue_item(MODE_ADD_EDGE, 0, 31, 0);
		queue_item(MODE_ADD_EDGE, 31, 0, 0);
		queue_item(MODE_ADD_EDGE, 5, 5, 0);
		queue_item(MODE_TRAVERSE, 5, 0, 0);
		queue_item(MODE_TRAVERSE, 31, 0, 0);
		queue_item(MODE_ADD_EDGE, 0, 1, 0);
		queue_item(MODE_ADD_EDGE, 1, 2, 0);
		queue_item(MODE_ADD_EDGE, 2, 3, 0);
		queue_item(MODE_ADD_EDGE, 16, 0, 0);
		queue_item(MODE_ADD_EDGE, 10, 21, 0);
		queue_item(MODE_TRAVERSE, 0, 31, 0);
		queue_item(MODE_TRAVERSE, 3, 0, 1);
		queue_item(MODE_TRAVERSE, 21, 10, 0);
		queue_item(MODE_TRAVERSE, 16, 0, 0);
		edges_made = 8;
		n = 16;
		base = $urandom_range(0, 31);
		// grow the graph up to and beyond a full store
		while (n < ITEM_TOTAL) begin
			drain = (n == 40) || ($urandom_range(0, 39) == 0);
			if ($urandom_range(0, 99) < ((edges_made < N_EDGE) ? 65 : 50)) begin
				if ($urandom_range(0, 9) == 0)
					base = $urandom_range(0, 31);
				queue_item(MODE_ADD_EDGE, pick_vertex(base), pick_vertex(base), drain);
				edges_made++;
			end else begin
				queue_item(MODE_TRAVERSE, $urandom_range(0, 31), $urandom_range(0, 31), drain);
			end
			n++;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (visit_expect.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && visit_expect.size() == 0)
			$display("graph_bfs_engine_test: clean");
		else
			$display("graph_bfs_engine_test: errors");
		$finish;
	end

endmodule
